// ----- design/nfa_to_dfa_subset_construction_defines.svh -----
// assertion macros shared by the subset construction checker
// no dependencies; included by files that hold concurrent assertions
`ifndef NFA_TO_DFA_SUBSET_CONSTRUCTION_DEFINES_SVH
`define NFA_TO_DFA_SUBSET_CONSTRUCTION_DEFINES_SVH

// property checked on every clock edge, skipped while reset is low
`define NTD_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// property checked on every clock edge, reset included
`define NTD_ASSERT_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/ntd_pkg.sv -----
// shared types and constants for the nfa to dfa subset construction block
// no dependencies; imported by the top level and the transition store
`default_nettype none

package ntd_pkg;

  // fixed field widths
  localparam int STATE_W = 3;
  localparam int SET_W   = 7;
  localparam int DEAD_IDX = 6;
  localparam logic [SET_W-1:0] DEAD_SET = 7'h40;

  // defaults for the top level parameters
  localparam int MAX_STATES_DEF  = 6;
  localparam int QUEUE_DEPTH_DEF = 64;

  // row limit of one run
  localparam int MAX_ROWS = 64;
  localparam int ROW_W    = 7;

  // request kinds
  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_RUN  = 1'b1
  } ntd_op_e;

  // register map, selected by address bit 2
  typedef enum logic [0:0] {
    CFG_NUM_STATES  = 1'b0,
    CFG_START_STATE = 1'b1
  } ntd_cfg_e;

  // run sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ROW,
    ST_ENQ0,
    ST_ENQ1
  } ntd_state_e;

  // transition load request toward the store
  typedef struct packed {
    logic               valid;
    logic [STATE_W-1:0] src;
    logic               sym;
    logic [STATE_W-1:0] tgt;
  } ntd_load_t;

endpackage

`default_nettype wire

// ----- design/nfa_to_dfa_subset_construction.sv -----
// Subset construction of a DFA from a two-symbol NFA without epsilon moves.
// A load request (tuser 0) adds one target state to the transition set of a
// source state on a symbol. A run request (tuser 1) walks the reachable subsets
// breadth first from {start_state} and emits one row per subset: the subset and
// its successors on 0 and 1, bit 6 standing for the dead state; tlast marks the
// final row, at most 64 rows per run. A run goes through the states READ, ROW,
// ENQ0 and ENQ1 for each row, set by the work queue RAM (a registered read, then
// the lookup) and its single write port, which takes the two successor subsets
// one after the other; a stalled result port holds the run in ENQ1. The output
// register holds a finished row while the next one is being built, and a new
// request is taken as soon as the last row sits in that register.
// Depends on ntd_pkg, ntd_trans_store and ntd_queue_ram.
`default_nettype none

module nfa_to_dfa_subset_construction #(
  parameter int MAX_STATES  = ntd_pkg::MAX_STATES_DEF,
  parameter int QUEUE_DEPTH = ntd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // source_state[2:0], symbol[3], target_state[6:4]
  input  wire logic        in_tuser,   // opcode
  // row channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [23:0] out_tdata,  // current_set[6:0], next_on_zero[13:7], next_on_one[20:14]
  output logic             out_tlast,  // last_row
  // register port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);
  import ntd_pkg::*;

  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  logic [STATE_W-1:0]    num_states_r;
  logic [STATE_W-1:0]    start_state_r;
  logic [STATE_W-1:0]    n_act;
  logic [MAX_STATES-1:0] active_mask;
  logic                  cfg_wr;

  ntd_state_e            state_r;
  ntd_state_e            state_nxt;
  logic                  in_acc;
  logic                  run_start;
  ntd_load_t             load_req;
  logic [SET_W-1:0]      start_set;

  logic [QAW-1:0]        head_r;
  logic [QAW-1:0]        tail_r;
  logic [QAW-1:0]        head_inc;
  logic [QAW-1:0]        tail_inc;
  logic [QCW-1:0]        count_r;
  logic [QCW-1:0]        count_after;
  logic [ROW_W-1:0]      rows_r;
  logic [127:0]          visited_r;

  logic                  ram_re;
  logic                  ram_we;
  logic [QAW-1:0]        ram_waddr;
  logic [SET_W-1:0]      ram_wdata;
  logic [SET_W-1:0]      ram_rdata;

  logic [SET_W-1:0]      n0_lk;
  logic [SET_W-1:0]      n1_lk;
  logic [SET_W-1:0]      cur_r;
  logic [SET_W-1:0]      n0_r;
  logic [SET_W-1:0]      n1_r;

  logic                  row_load;
  logic                  enq_try;
  logic                  do_enq;
  logic [SET_W-1:0]      cand;
  logic                  out_free;
  logic                  out_load;
  logic                  last_row;

  logic                  out_valid_r;
  logic [SET_W-1:0]      out_cur_r;
  logic [SET_W-1:0]      out_n0_r;
  logic [SET_W-1:0]      out_n1_r;
  logic                  out_last_r;

  // register port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_states_r  <= STATE_W'(1);
      start_state_r <= '0;
    end else if (cfg_wr) begin
      case (ntd_cfg_e'(cfg_paddr[2]))
        CFG_NUM_STATES:  num_states_r  <= cfg_pwdata[STATE_W-1:0];
        CFG_START_STATE: start_state_r <= cfg_pwdata[STATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ntd_cfg_e'(cfg_paddr[2]))
      CFG_NUM_STATES:  cfg_prdata = {29'd0, num_states_r};
      CFG_START_STATE: cfg_prdata = {29'd0, start_state_r};
      default:         cfg_prdata = '0;
    endcase
  end

  // state count clamped to 1..MAX_STATES, and its mask
  always_comb begin
    if (num_states_r == '0) begin
      n_act = STATE_W'(1);
    end else if (num_states_r > STATE_W'(MAX_STATES)) begin
      n_act = STATE_W'(MAX_STATES);
    end else begin
      n_act = num_states_r;
    end
    for (int s = 0; s < MAX_STATES; s++) begin
      active_mask[s] = (STATE_W'(s) < n_act);
    end
  end

  // request decode
  assign in_acc    = in_tvalid && in_tready;
  assign run_start = in_acc && (ntd_op_e'(in_tuser) == OP_RUN);

  assign load_req.valid = in_acc && (ntd_op_e'(in_tuser) == OP_LOAD);
  assign load_req.src   = in_tdata[2:0];
  assign load_req.sym   = in_tdata[3];
  assign load_req.tgt   = in_tdata[6:4];

  assign start_set = (start_state_r < n_act) ? (SET_W'(1) << start_state_r) : DEAD_SET;

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (run_start) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_ROW;
      ST_ROW:  state_nxt = ST_ENQ0;
      ST_ENQ0: state_nxt = ST_ENQ1;
      ST_ENQ1: begin
        if (out_free) state_nxt = last_row ? ST_IDLE : ST_READ;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    ram_re    = 1'b0;
    row_load  = 1'b0;
    enq_try   = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_READ: ram_re    = 1'b1;
      ST_ROW:  row_load  = 1'b1;
      ST_ENQ0: enq_try   = 1'b1;
      ST_ENQ1: begin
        enq_try  = out_free;
        out_load = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // enqueue of a successor not yet seen, when the queue has room
  assign cand        = (state_r == ST_ENQ1) ? n1_r : n0_r;
  assign do_enq      = enq_try && !visited_r[cand] && (count_r != QCW'(QUEUE_DEPTH));
  assign count_after = count_r + QCW'(do_enq);
  assign last_row    = (count_after == '0) || (rows_r == ROW_W'(MAX_ROWS));
  assign out_free    = !out_valid_r || out_tready;

  // circular pointers
  assign head_inc = (head_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_r + QAW'(1);
  assign tail_inc = (tail_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + QAW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      rows_r  <= '0;
    end else if (run_start) begin
      head_r  <= '0;
      tail_r  <= QAW'(1);
      count_r <= QCW'(1);
      rows_r  <= '0;
    end else begin
      if (ram_re) begin
        head_r  <= head_inc;
        count_r <= count_r - QCW'(1);
      end else if (do_enq) begin
        tail_r  <= tail_inc;
        count_r <= count_after;
      end
      if (row_load) begin
        rows_r <= rows_r + ROW_W'(1);
      end
    end
  end

  // visited subsets, cleared at run start with only the start subset marked
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      visited_r <= '0;
    end else if (run_start) begin
      visited_r <= 128'd1 << start_set;
    end else if (do_enq) begin
      visited_r[cand] <= 1'b1;
    end
  end

  // work queue
  assign ram_we    = run_start || do_enq;
  assign ram_waddr = run_start ? '0 : tail_r;
  assign ram_wdata = run_start ? start_set : cand;

  ntd_queue_ram #(
    .DEPTH  (QUEUE_DEPTH),
    .WIDTH  (SET_W),
    .ADDR_W (QAW)
  ) u_queue (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr   (head_r),
    .rdata_r (ram_rdata)
  );

  // transition store and successor lookup
  ntd_trans_store #(
    .MAX_STATES (MAX_STATES)
  ) u_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .load_req    (load_req),
    .num_states  (num_states_r),
    .active_mask (active_mask),
    .cur_set     (ram_rdata),
    .next_zero   (n0_lk),
    .next_one    (n1_lk)
  );

  // row under construction
  always_ff @(posedge clk) begin
    if (row_load) begin
      cur_r <= ram_rdata;
      n0_r  <= n0_lk;
      n1_r  <= n1_lk;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_cur_r  <= cur_r;
      out_n0_r   <= n0_r;
      out_n1_r   <= n1_r;
      out_last_r <= last_row;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_n1_r, out_n0_r, out_cur_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// ----- design/ntd_queue_ram.sv -----
// work queue storage: one write port, one registered read port
// depends on nothing but its parameters
`default_nettype none

module ntd_queue_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 7,
  parameter int ADDR_W = 6
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- design/ntd_trans_store.sv -----
// nfa transition sets per state and symbol, with successor lookup of a subset
// depends on ntd_pkg
`default_nettype none

module ntd_trans_store #(
  parameter int MAX_STATES = 6
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire ntd_pkg::ntd_load_t          load_req,
  input  wire logic [ntd_pkg::STATE_W-1:0] num_states,
  input  wire logic [MAX_STATES-1:0]       active_mask,
  input  wire logic [ntd_pkg::SET_W-1:0]   cur_set,
  output logic      [ntd_pkg::SET_W-1:0]   next_zero,
  output logic      [ntd_pkg::SET_W-1:0]   next_one
);
  import ntd_pkg::*;

  localparam int ENTRIES = 2 * MAX_STATES;
  localparam int ENTRY_W = STATE_W + 1;

  logic [MAX_STATES-1:0] store_r [ENTRIES];
  logic [MAX_STATES-1:0] tgt_mask;
  logic                  load_ok;
  logic [ENTRY_W-1:0]    load_entry;
  logic [MAX_STATES-1:0] acc0;
  logic [MAX_STATES-1:0] acc1;

  // accept only in-range source and target
  assign load_ok = load_req.valid
                && (load_req.src < STATE_W'(MAX_STATES))
                && (load_req.tgt < num_states)
                && (load_req.tgt < STATE_W'(MAX_STATES));
  assign load_entry = {load_req.src, load_req.sym};

  // one-hot target bit
  always_comb begin
    tgt_mask = '0;
    for (int b = 0; b < MAX_STATES; b++) begin
      tgt_mask[b] = (load_req.tgt == STATE_W'(b));
    end
  end

  // set update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int e = 0; e < ENTRIES; e++) begin
        store_r[e] <= '0;
      end
    end else if (load_ok) begin
      for (int e = 0; e < ENTRIES; e++) begin
        if (ENTRY_W'(e) == load_entry) begin
          store_r[e] <= store_r[e] | tgt_mask;
        end
      end
    end
  end

  // union of member transitions on both symbols
  always_comb begin
    acc0 = '0;
    acc1 = '0;
    for (int s = 0; s < MAX_STATES; s++) begin
      if (cur_set[s]) begin
        acc0 = acc0 | store_r[2*s];
        acc1 = acc1 | store_r[2*s+1];
      end
    end
    acc0 = acc0 & active_mask;
    acc1 = acc1 & active_mask;
  end

  // empty union and dead input both give the dead state
  assign next_zero = (cur_set[DEAD_IDX] || (acc0 == '0)) ? DEAD_SET : SET_W'(acc0);
  assign next_one  = (cur_set[DEAD_IDX] || (acc1 == '0)) ? DEAD_SET : SET_W'(acc1);

endmodule

`default_nettype wire

// ----- design/ntd_checker.sv -----
// port-level checks of the subset construction block, bound to the top level
// depends on nfa_to_dfa_subset_construction_defines.svh
`default_nettype none

`include "nfa_to_dfa_subset_construction_defines.svh"

module ntd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic        out_tlast
);

  // no row right after reset
  `NTD_ASSERT_ALL(a_rst_no_row, clk, !rst_n |=> !out_tvalid, "row valid after reset")

  // stalled row holds
  `NTD_ASSERT_RST(a_row_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled row changed")

  // a row never carries the empty subset
  `NTD_ASSERT_RST(a_row_nonempty, clk, rst_n, out_tvalid |-> out_tdata[6:0] != 7'h00 && out_tdata[13:7] != 7'h00 && out_tdata[20:14] != 7'h00, "empty subset in row")

  // the dead state loops to itself on both symbols
  `NTD_ASSERT_RST(a_dead_loops, clk, rst_n, out_tvalid && out_tdata[6] |-> out_tdata[6:0] == 7'h40 && out_tdata[13:7] == 7'h40 && out_tdata[20:14] == 7'h40, "dead state row wrong")

endmodule

bind nfa_to_dfa_subset_construction ntd_checker u_ntd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// self-checking bench for the nfa to dfa subset construction block
// drives load and run requests plus register writes, predicts every dfa row
// depends on ntd_pkg and the nfa_to_dfa_subset_construction top level
`default_nettype none

module tb_top;
  import ntd_pkg::*;

  localparam int MAX_ST     = MAX_STATES_DEF;
  localparam int WALK_DEPTH = QUEUE_DEPTH_DEF;
  localparam int SETTLE_CYC = 8;
  localparam int HOLD_CYC   = 400;
  localparam int PHASES     = 8;
  localparam int PHASE_REQS = 15;
  localparam int PRINT_CAP  = 100;

  // one dfa row as the block reports it
  typedef struct packed {
    logic [SET_W-1:0] cur;
    logic [SET_W-1:0] n0;
    logic [SET_W-1:0] n1;
    logic             last;
  } dfa_row_t;

  // kinds of directed steps
  typedef enum logic [1:0] {
    STEP_CFG,
    STEP_REQ,
    STEP_REQ_CHK
  } step_kind_e;

  typedef struct packed {
    step_kind_e         kind;
    ntd_cfg_e           sel;
    logic [2:0]         val;
    ntd_op_e            op;
    logic [STATE_W-1:0] src;
    logic               sym;
    logic [STATE_W-1:0] tgt;
    dfa_row_t           row;
  } dir_step_t;

  // directed steps; typed rows hold the first row that a run must give
  localparam int DIR_N = 25;
  localparam dir_step_t DIR_TAB [DIR_N] = '{
    // empty store after reset: start goes dead on both symbols
    '{STEP_REQ_CHK, CFG_NUM_STATES, 3'd0, OP_RUN, 3'd0, 1'b0, 3'd0,
      '{7'h01, DEAD_SET, DEAD_SET, 1'b0}},
    // zero states: taken as one, loads all refused
    '{STEP_CFG, CFG_NUM_STATES, 3'd0, OP_LOAD, 3'd0, 1'b0, 3'd0, '0},
    '{STEP_REQ, CFG_NUM_STATES, 3'd0, OP_LOAD, 3'd0, 1'b0, 3'd0, '0},
    '{STEP_REQ_CHK, CFG_NUM_STATES, 3'd0, OP_RUN, 3'd0, 1'b0, 3'd0,
      '{7'h01, DEAD_SET, DEAD_SET, 1'b0}},
    // seven states clamps to six, start beyond range gives the dead state
    '{STEP_CFG, CFG_NUM_STATES, 3'd7, OP_LOAD, 3'd0, 1'b0, 3'd0, '0},
    '{STEP_CFG, CFG_START_STATE, 3'd7, OP_LOAD, 3'd0, 1'b0, 3'd0, '0},
    '{STEP_REQ_CHK, CFG_NUM_STATES, 3'd0, OP_RUN, 3'd0, 1'b0, 3'd0,
      '{DEAD_SET, DEAD_SET, DEAD_SET, 1'b1}},
    '{STEP_CFG, CFG_START_STATE, 3'd0, OP_LOAD, 3'd0, 1'b0, 3'd0, '0},
    // loads: good ones, target out of range, source out of range
    '{STEP_REQ, CFG_NUM_STATES, 3'd0, OP_LOAD, 3'd0, 1'b0, 3'd1, '0},
    '{STEP_REQ, CFG_NUM_STATES, 3'd0, OP_LOAD, 3'd0, 1'b1, 3'd7, '0},
    '{STEP_REQ, CFG_NUM_STATES, 3'd0, OP_LOAD, 3'd7, 1'b1, 3'd2, '0},
    '{STEP_REQ, CFG_NUM_STATES, 3'd0, OP_LOAD, 3'd1, 1'b1, 3'd6, '0},
    '{STEP_REQ, CFG_NUM_STATES, 3'd0, OP_LOAD, 3'd1, 1'b0, 3'd5, '0},
    '{STEP_REQ, CFG_NUM_STATES, 3'd0, OP_LOAD, 3'd5, 1'b1, 3'd0, '0},
    '{STEP_REQ, CFG_NUM_STATES, 3'd0, OP_LOAD, 3'd5, 1'b0, 3'd5, '0},
    '{STEP_REQ, CFG_NUM_STATES, 3'd0, OP_LOAD, 3'd2, 1'b0, 3'd3, '0},
    '{STEP_REQ, CFG_NUM_STATES, 3'd0, OP_LOAD, 3'd3, 1'b1, 3'd4, '0},
    '{STEP_REQ, CFG_NUM_STATES, 3'd0, OP_LOAD, 3'd4, 1'b0, 3'd2, '0},
    '{STEP_REQ, CFG_NUM_STATES, 3'd0, OP_RUN, 3'd0, 1'b0, 3'd0, '0},
    // shrink: stored targets above the count are masked
    '{STEP_CFG, CFG_NUM_STATES, 3'd2, OP_LOAD, 3'd0, 1'b0, 3'd0, '0},
    '{STEP_REQ, CFG_NUM_STATES, 3'd0, OP_RUN, 3'd7, 1'b1, 3'd7, '0},
    '{STEP_CFG, CFG_NUM_STATES, 3'd6, OP_LOAD, 3'd0, 1'b0, 3'd0, '0},
    '{STEP_CFG, CFG_START_STATE, 3'd5, OP_LOAD, 3'd0, 1'b0, 3'd0, '0},
    '{STEP_REQ, CFG_NUM_STATES, 3'd0, OP_RUN, 3'd0, 1'b0, 3'd0, '0},
    '{STEP_REQ, CFG_NUM_STATES, 3'd0, OP_LOAD, 3'd6, 1'b1, 3'd3, '0}
  };

  // dut signals
  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = '0;
  logic        in_tuser    = 1'b0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // predictor state: transition sets, registers, visited map and walk fifo
  logic [MAX_ST-1:0]  trans_sets [2*MAX_ST];
  logic [2:0]         num_states_q;
  logic [2:0]         start_state_q;
  bit                 visited_q [128];
  logic [SET_W-1:0]   walk_fifo [WALK_DEPTH];
  int unsigned        walk_head;
  int unsigned        walk_tail;

  dfa_row_t dfa_rows_due [$];
  int       err_cnt     = 0;
  bit       hold_req    = 1'b0;
  bit       valid_on    = 1'b0;
  int       burst_left  = 0;

  nfa_to_dfa_subset_construction i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #10000000;
    $display("TB_ERROR");
    $finish;
  end

  // number of states actually in use
  function automatic int states_in_use();
    if (num_states_q == 3'd0) return 1;
    if (num_states_q > MAX_ST) return MAX_ST;
    return num_states_q;
  endfunction

  // successor subset of one subset on one symbol
  function automatic logic [SET_W-1:0] next_subset(input logic [SET_W-1:0] set,
                                                   input bit sym, input int n);
    logic [SET_W-1:0] acc;
    acc = '0;
    if (set[DEAD_IDX]) return DEAD_SET;
    for (int s = 0; s < n; s++)
      if (set[s]) acc = acc | SET_W'(trans_sets[s*2 + sym]);
    acc = acc & ((SET_W'(1) << n) - SET_W'(1));
    if (acc == '0) acc = DEAD_SET;
    return acc;
  endfunction

  // queue a subset once per run, dropped when the fifo is full
  function automatic void queue_subset(input logic [SET_W-1:0] set);
    if (visited_q[set]) return;
    if (walk_tail - walk_head >= WALK_DEPTH) return;
    walk_fifo[walk_tail % WALK_DEPTH] = set;
    walk_tail++;
    visited_q[set] = 1'b1;
  endfunction

  // breadth first walk, appends every row of the run; returns the row count
  function automatic int build_dfa_rows();
    int n;
    int rows;
    logic [SET_W-1:0] cur;
    dfa_row_t r;
    n = states_in_use();
    rows = 0;
    foreach (visited_q[i]) visited_q[i] = 1'b0;
    walk_head = 0;
    walk_tail = 0;
    queue_subset((start_state_q < n) ? SET_W'(1 << start_state_q) : DEAD_SET);
    while (walk_head != walk_tail && rows < MAX_ROWS) begin
      cur = walk_fifo[walk_head % WALK_DEPTH];
      walk_head++;
      r.cur = cur;
      r.n0 = next_subset(cur, 1'b0, n);
      queue_subset(r.n0);
      r.n1 = next_subset(cur, 1'b1, n);
      queue_subset(r.n1);
      rows++;
      r.last = (walk_head == walk_tail) || (rows == MAX_ROWS);
      dfa_rows_due.insert(dfa_rows_due.size(), r);
    end
    return rows;
  endfunction

  // request accepted: update the store or predict the run
  function automatic int apply_request(input ntd_op_e op, input logic [2:0] src,
                                       input logic sym, input logic [2:0] tgt);
    if (op == OP_RUN) return build_dfa_rows();
    if (src < MAX_ST && tgt < num_states_q && tgt < MAX_ST)
      trans_sets[src*2 + sym][tgt] = 1'b1;
    return 0;
  endfunction

  // one line per bad row, printing capped but every one counted
  task automatic report_mismatch(input string what, input dfa_row_t got,
                                 input dfa_row_t want);
    if (err_cnt < PRINT_CAP)
      $display("mismatch %s: got cur=%h n0=%h n1=%h last=%b want cur=%h n0=%h n1=%h last=%b",
               what, got.cur, got.n0, got.n1, got.last,
               want.cur, want.n0, want.n1, want.last);
    err_cnt++;
  endtask

  // send one request, in bursts with random gaps; returns rows it predicts
  task automatic send_request(input ntd_op_e op, input logic [2:0] src,
                              input logic sym, input logic [2:0] tgt,
                              output int rows);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        if (valid_on) in_tvalid <= 1'b0;
        valid_on = 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    if (!valid_on) in_tvalid <= 1'b1;
    valid_on = 1'b1;
    in_tdata <= {1'b0, tgt, sym, src};
    in_tuser <= op;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    rows = apply_request(op, src, sym, tgt);
  endtask

  // drop the request valid and let the block go idle
  task automatic wait_idle(input int extra);
    if (valid_on) in_tvalid <= 1'b0;
    valid_on = 1'b0;
    burst_left = 0;
    while (dfa_rows_due.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // register write: setup phase, access phase, then a spare idle wait
  task automatic write_reg(input ntd_cfg_e sel, input logic [2:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {sel, 2'b00};
    cfg_pwdata  <= {29'd0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (sel == CFG_NUM_STATES) num_states_q = val;
    else start_state_q = val;
    @(posedge clk);
  endtask

  // row sink: checks each accepted row, stalls on its own pattern
  initial begin : row_sink
    int mode;
    int mode_left;
    int hold_left;
    dfa_row_t got;
    dfa_row_t want;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got.cur  = out_tdata[6:0];
        got.n0   = out_tdata[13:7];
        got.n1   = out_tdata[20:14];
        got.last = out_tlast;
        if (dfa_rows_due.size() == 0) begin
          report_mismatch("row with none expected", got, '0);
        end else begin
          want = dfa_rows_due.pop_front();
          if (got !== want) report_mismatch("row fields", got, want);
        end
      end
      // long hold-off on request, else a stall pattern that changes now and then
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYC;
        out_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(16, 80);
        end
        mode_left--;
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= $urandom_range(0, 1);
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int rows;
    int n;
    int k;
    bit well_formed;
    logic [2:0] src;
    logic [2:0] tgt;
    ntd_op_e op;
    foreach (trans_sets[i]) trans_sets[i] = '0;
    foreach (visited_q[i]) visited_q[i] = 1'b0;
    walk_head = 0;
    walk_tail = 0;
    num_states_q = 3'd1;
    start_state_q = 3'd0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int i = 0; i < DIR_N; i++) begin
      if (DIR_TAB[i].kind == STEP_CFG) begin
        wait_idle(SETTLE_CYC);
        write_reg(DIR_TAB[i].sel, DIR_TAB[i].val);
      end else begin
        send_request(DIR_TAB[i].op, DIR_TAB[i].src, DIR_TAB[i].sym, DIR_TAB[i].tgt, rows);
        if (DIR_TAB[i].kind == STEP_REQ_CHK && rows > 0)
          dfa_rows_due[dfa_rows_due.size() - rows] = DIR_TAB[i].row;
      end
    end

    // random phases, each under its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle(SETTLE_CYC);
      case (ph)
        0: write_reg(CFG_NUM_STATES, 3'd1);
        1: write_reg(CFG_NUM_STATES, 3'd6);
        2: write_reg(CFG_NUM_STATES, 3'd6);
        default: write_reg(CFG_NUM_STATES, 3'($urandom_range(0, 7)));
      endcase
      n = states_in_use();
      if ($urandom_range(0, 3) != 0) write_reg(CFG_START_STATE, 3'($urandom_range(0, n - 1)));
      else write_reg(CFG_START_STATE, 3'($urandom_range(0, 7)));
      // one phase stalls the row side for a long stretch while requests keep coming
      if (ph == 2) hold_req = 1'b1;
      for (k = 0; k < PHASE_REQS; k++) begin
        if ((ph == 2 && k == 0) || k == PHASE_REQS - 1 || $urandom_range(0, 3) == 0)
          op = OP_RUN;
        else
          op = OP_LOAD;
        well_formed = ($urandom_range(0, 6) != 0);
        src = well_formed ? 3'($urandom_range(0, MAX_ST - 1)) : 3'($urandom_range(0, 7));
        tgt = well_formed ? 3'($urandom_range(0, n - 1)) : 3'($urandom_range(0, 7));
        send_request(op, src, 1'($urandom_range(0, 1)), tgt, rows);
      end
    end

    // drain, then judge
    wait_idle(20);
    if (dfa_rows_due.size() != 0)
      report_mismatch("expected row never came", '0, dfa_rows_due[0]);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
